FILE: rtl/dfla_pkg.sv
package dfla_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_PRESSURE_LIMIT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DRIVER_POLLS   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESSURE_POLLS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STOP_POLLS     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MUTE_MS        = 3'd4;

  localparam logic signed [15:0] PRESSURE_LIMIT_RST = 16'sd400;
  localparam logic [7:0]         DRIVER_POLLS_RST   = 8'd5;
  localparam logic [7:0]         PRESSURE_POLLS_RST = 8'd3;
  localparam logic [7:0]         STOP_POLLS_RST     = 8'd3;
  localparam logic [15:0]        MUTE_MS_RST        = 16'd4000;

  localparam logic [1:0] OP_POLL  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] TONE_OFF        = 2'd0;
  localparam logic [1:0] TONE_CRITICAL   = 2'd1;
  localparam logic [1:0] TONE_DISCONNECT = 2'd2;
  localparam logic [1:0] TONE_WARNING    = 2'd3;

  localparam int unsigned BIT_DRIVER     = 0;
  localparam int unsigned BIT_PRESSURE   = 1;
  localparam int unsigned BIT_STOP       = 2;
  localparam int unsigned BIT_DISCONNECT = 3;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic signed [15:0] pressure_limit;
    logic [7:0]         driver_alarm_polls;
    logic [7:0]         pressure_polls;
    logic [7:0]         stop_polls;
    logic [15:0]        mute_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic               driver_alarm;
    logic signed [15:0] pressure;
    logic               stop_open;
    logic [31:0]        now_ms;
    logic [7:0]         set_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] fault_code;
    logic       faulted;
    logic       motor_disable;
    logic       red_led;
    logic [1:0] tone;
    logic       reboot_request;
  } out_item_t;

endpackage

FILE: rtl/dfla_if.sv
interface dfla_in_if;
  import dfla_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface dfla_out_if;
  import dfla_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/dfla_cfg_regs.sv
module dfla_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dfla_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dfla_pkg::CfgDataW-1:0]   cfg_data_i,
  output dfla_pkg::cfg_t                  cfg_o
);
  import dfla_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PRESSURE_LIMIT: cfg_d.pressure_limit     = $signed(cfg_data_i);
        REG_DRIVER_POLLS:   cfg_d.driver_alarm_polls = cfg_data_i[7:0];
        REG_PRESSURE_POLLS: cfg_d.pressure_polls     = cfg_data_i[7:0];
        REG_STOP_POLLS:     cfg_d.stop_polls         = cfg_data_i[7:0];
        REG_MUTE_MS:        cfg_d.mute_ms            = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressure_limit     <= PRESSURE_LIMIT_RST;
      cfg_q.driver_alarm_polls <= DRIVER_POLLS_RST;
      cfg_q.pressure_polls     <= PRESSURE_POLLS_RST;
      cfg_q.stop_polls         <= STOP_POLLS_RST;
      cfg_q.mute_ms            <= MUTE_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/dfla_in_stage.sv
module dfla_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  dfla_pkg::in_item_t   item_i,
  output logic                 valid_o,
  input  logic                 take_i,
  output dfla_pkg::in_item_t   item_o
);
  import dfla_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/dfla_core.sv
module dfla_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  dfla_pkg::cfg_t       cfg_i,
  input  dfla_pkg::in_item_t   item_i,
  output dfla_pkg::out_item_t  result_o
);
  import dfla_pkg::*;

  logic [7:0]  fault_bits_q, fault_bits_d;
  logic [7:0]  driver_count_q, driver_count_d;
  logic [7:0]  pressure_count_q, pressure_count_d;
  logic [7:0]  stop_count_q, stop_count_d;
  logic [31:0] fault_start_q, fault_start_d;
  logic        start_valid_q, start_valid_d;
  logic        motor_off_q, motor_off_d;
  logic        red_q, red_d;
  logic [1:0]  tone_q, tone_d;

  logic        over_pressure;
  logic [7:0]  driver_inc, pressure_inc, stop_inc;
  logic        driver_hit, pressure_hit, stop_hit;
  logic [7:0]  poll_bits;
  logic [31:0] start_sel;
  logic [31:0] elapsed;
  logic        tone_on;
  logic [1:0]  poll_tone;
  logic        reboot;

  always_comb begin
    over_pressure = item_i.pressure > cfg_i.pressure_limit;
    driver_inc   = (driver_count_q == COUNT_MAX) ? COUNT_MAX : driver_count_q + 8'd1;
    pressure_inc = (pressure_count_q == COUNT_MAX) ? COUNT_MAX : pressure_count_q + 8'd1;
    stop_inc     = (stop_count_q == COUNT_MAX) ? COUNT_MAX : stop_count_q + 8'd1;
    driver_hit   = item_i.driver_alarm && (driver_inc >= cfg_i.driver_alarm_polls);
    pressure_hit = over_pressure && (pressure_inc >= cfg_i.pressure_polls);
    stop_hit     = item_i.stop_open && (stop_inc >= cfg_i.stop_polls);

    poll_bits = fault_bits_q;
    poll_bits[BIT_DRIVER]   = fault_bits_q[BIT_DRIVER] | driver_hit;
    poll_bits[BIT_PRESSURE] = fault_bits_q[BIT_PRESSURE] | pressure_hit;
    poll_bits[BIT_STOP]     = fault_bits_q[BIT_STOP] | stop_hit;

    start_sel = start_valid_q ? fault_start_q : item_i.now_ms;
    elapsed   = item_i.now_ms - start_sel;
    tone_on   = (elapsed < {16'd0, cfg_i.mute_ms}) || poll_bits[BIT_STOP];
    if (!tone_on) begin
      poll_tone = TONE_OFF;
    end else if (poll_bits[BIT_STOP] || poll_bits[BIT_PRESSURE]) begin
      poll_tone = TONE_CRITICAL;
    end else if (poll_bits[BIT_DISCONNECT]) begin
      poll_tone = TONE_DISCONNECT;
    end else begin
      poll_tone = TONE_WARNING;
    end

    fault_bits_d     = fault_bits_q;
    driver_count_d   = driver_count_q;
    pressure_count_d = pressure_count_q;
    stop_count_d     = stop_count_q;
    fault_start_d    = fault_start_q;
    start_valid_d    = start_valid_q;
    motor_off_d      = motor_off_q;
    red_d            = red_q;
    tone_d           = tone_q;
    reboot           = 1'b0;

    case (item_i.operation)
      OP_POLL: begin
        driver_count_d   = item_i.driver_alarm ? driver_inc : 8'd0;
        pressure_count_d = over_pressure ? pressure_inc : 8'd0;
        stop_count_d     = item_i.stop_open ? stop_inc : 8'd0;
        fault_bits_d     = poll_bits;
        reboot           = !item_i.stop_open && poll_bits[BIT_STOP];
        if (poll_bits != 8'd0) begin
          motor_off_d   = 1'b1;
          red_d         = 1'b1;
          fault_start_d = start_sel;
          start_valid_d = 1'b1;
          tone_d        = poll_tone;
        end else begin
          start_valid_d = 1'b0;
        end
      end
      OP_SET: begin
        fault_bits_d = fault_bits_q | item_i.set_bits;
      end
      OP_CLEAR: begin
        fault_bits_d = 8'd0;
        red_d        = 1'b0;
        tone_d       = TONE_OFF;
      end
      default: begin
        fault_bits_d = fault_bits_q;
      end
    endcase

    result_o.fault_code     = fault_bits_d;
    result_o.faulted        = fault_bits_d != 8'd0;
    result_o.motor_disable  = motor_off_d;
    result_o.red_led        = red_d;
    result_o.tone           = tone_d;
    result_o.reboot_request = reboot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_bits_q     <= 8'd0;
      driver_count_q   <= 8'd0;
      pressure_count_q <= 8'd0;
      stop_count_q     <= 8'd0;
      fault_start_q    <= 32'd0;
      start_valid_q    <= 1'b0;
      motor_off_q      <= 1'b0;
      red_q            <= 1'b0;
      tone_q           <= TONE_OFF;
    end else if (step_i) begin
      fault_bits_q     <= fault_bits_d;
      driver_count_q   <= driver_count_d;
      pressure_count_q <= pressure_count_d;
      stop_count_q     <= stop_count_d;
      fault_start_q    <= fault_start_d;
      start_valid_q    <= start_valid_d;
      motor_off_q      <= motor_off_d;
      red_q            <= red_d;
      tone_q           <= tone_d;
    end
  end

endmodule

FILE: rtl/debounced_fault_latch_alarm.sv
// Debounced fault latch and alarm driver.
//
// Items arrive on in_i (valid/ready) as poll, set-fault or clear requests,
// and each item produces exactly one result item on out_o (valid/ready).
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i only while the block is idle; the user must keep to this, as
// the block itself does not enforce it. Writes take effect at the next edge.
//
// An accepted item is held in an input register, processed against the
// fault state and placed in the result register, which drives out_o. One
// item per cycle is sustained while the receiver does not stall.
//
// Reset clears all fault state, counters and held outputs and loads the
// register defaults. When the receiver stalls, the result register holds
// its item, the input register takes one more item, and in_i.ready then
// drops until the result is taken.
module debounced_fault_latch_alarm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dfla_in_if.sink                        in_i,
  dfla_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [dfla_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dfla_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dfla_pkg::*;

  cfg_t      cfg;
  in_item_t  stage_item;
  logic      stage_valid;
  logic      advance;
  out_item_t result;
  logic      out_valid_q;
  out_item_t out_item_q;

  assign advance = stage_valid && (!out_valid_q || out_o.ready);

  dfla_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dfla_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_i.item),
    .valid_o (stage_valid),
    .take_i  (advance),
    .item_o  (stage_item)
  );

  dfla_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .cfg_i    (cfg),
    .item_i   (stage_item),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= stage_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

endmodule

FILE: rtl/dfla_checker.sv
module dfla_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  dfla_pkg::out_item_t  out_item_i
);
  import dfla_pkg::*;

  a_faulted_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_item_i.faulted == (out_item_i.fault_code != 8'd0)))
    else $error("faulted does not match fault_code");

  a_red_needs_motor_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_item_i.red_led) |-> out_item_i.motor_disable)
    else $error("red lamp lit without motor disable");

  a_tone_needs_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_item_i.tone != TONE_OFF)) |-> out_item_i.red_led)
    else $error("tone active without red lamp");

  a_reboot_needs_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_item_i.reboot_request) |-> out_item_i.fault_code[BIT_STOP])
    else $error("reboot request without stop fault");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_item_i)))
    else $error("result item changed while stalled");

endmodule

bind debounced_fault_latch_alarm dfla_checker u_dfla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.item)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dfla_pkg::*;

  localparam logic [1:0] OpUnused   = 2'd3;
  localparam int         HoldCycles = 60;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dfla_in_if  in_if ();
  dfla_out_if out_if ();

  debounced_fault_latch_alarm uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic signed [15:0] limit_q     = PRESSURE_LIMIT_RST;
  logic [7:0]         drv_polls_q = DRIVER_POLLS_RST;
  logic [7:0]         prs_polls_q = PRESSURE_POLLS_RST;
  logic [7:0]         stp_polls_q = STOP_POLLS_RST;
  logic [15:0]        mute_q      = MUTE_MS_RST;

  logic [7:0]  bits_q      = '0;
  logic [7:0]  drv_cnt_q   = '0;
  logic [7:0]  prs_cnt_q   = '0;
  logic [7:0]  stp_cnt_q   = '0;
  logic [31:0] start_ms_q  = '0;
  bit          start_ok_q  = 1'b0;
  bit          motor_off_q = 1'b0;
  bit          red_q       = 1'b0;
  logic [1:0]  tone_q      = TONE_OFF;

  out_item_t   pending_status[$];
  int unsigned mismatches  = 0;
  logic [31:0] ms_clock    = '0;
  bit          src_gaps    = 1'b1;
  bit          sink_stalls = 1'b1;
  bit          hold_req    = 1'b0;

  function automatic logic [7:0] debounce_step(logic [7:0] cnt, bit active);
    if (!active) return '0;
    return (cnt == COUNT_MAX) ? cnt : cnt + 8'd1;
  endfunction

  function automatic out_item_t predict_status(in_item_t it);
    out_item_t r;
    bit        over;
    bit        reboot;
    reboot = 1'b0;
    over   = $signed(it.pressure) > limit_q;
    case (it.operation)
      OP_POLL: begin
        drv_cnt_q = debounce_step(drv_cnt_q, it.driver_alarm);
        if (it.driver_alarm && drv_cnt_q >= drv_polls_q) bits_q[BIT_DRIVER] = 1'b1;
        prs_cnt_q = debounce_step(prs_cnt_q, over);
        if (over && prs_cnt_q >= prs_polls_q) bits_q[BIT_PRESSURE] = 1'b1;
        stp_cnt_q = debounce_step(stp_cnt_q, it.stop_open);
        if (it.stop_open && stp_cnt_q >= stp_polls_q) bits_q[BIT_STOP] = 1'b1;
        reboot = !it.stop_open && bits_q[BIT_STOP];
        if (bits_q != '0) begin
          motor_off_q = 1'b1;
          red_q       = 1'b1;
          if (!start_ok_q) begin
            start_ms_q = it.now_ms;
            start_ok_q = 1'b1;
          end
          if ((it.now_ms - start_ms_q) < {16'h0000, mute_q} || bits_q[BIT_STOP]) begin
            if (bits_q[BIT_STOP] || bits_q[BIT_PRESSURE]) tone_q = TONE_CRITICAL;
            else if (bits_q[BIT_DISCONNECT]) tone_q = TONE_DISCONNECT;
            else tone_q = TONE_WARNING;
          end else begin
            tone_q = TONE_OFF;
          end
        end else begin
          start_ok_q = 1'b0;
        end
      end
      OP_SET: bits_q |= it.set_bits;
      OP_CLEAR: begin
        bits_q = '0;
        red_q  = 1'b0;
        tone_q = TONE_OFF;
      end
      default: ;
    endcase
    r.fault_code     = bits_q;
    r.faulted        = |bits_q;
    r.motor_disable  = motor_off_q;
    r.red_led        = red_q;
    r.tone           = tone_q;
    r.reboot_request = reboot;
    return r;
  endfunction

  function automatic in_item_t mk(logic [1:0] op, bit alarm, int p, bit open,
                                  logic [31:0] now, logic [7:0] bits);
    in_item_t it;
    it.operation    = op;
    it.driver_alarm = alarm;
    it.pressure     = 16'(p);
    it.stop_open    = open;
    it.now_ms       = now;
    it.set_bits     = bits;
    return it;
  endfunction

  function automatic in_item_t noise_item(logic [1:0] op);
    return mk(op, 1'($urandom()), int'(16'($urandom())), 1'($urandom()), $urandom(),
              8'($urandom()));
  endfunction

  function automatic in_item_t poll_item(bit alarm, bit over, bit open);
    int lim;
    int p;
    lim = int'(limit_q);
    if (over && lim < 32767) p = lim + 1 + int'($urandom_range(0, 32766 - lim));
    else p = -32768 + int'($urandom_range(0, lim + 32768));
    ms_clock += $urandom_range(0, 1500);
    if ($urandom_range(0, 31) == 0) ms_clock = $urandom();
    return mk(OP_POLL, alarm, p, open, ms_clock, 8'($urandom()));
  endfunction

  task automatic send_item(in_item_t it);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.item  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    pending_status.push_back(predict_status(it));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(logic signed [15:0] limit, logic [7:0] drv, logic [7:0] prs,
                           logic [7:0] stp, logic [15:0] mute);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_PRESSURE_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_idx_i  <= REG_DRIVER_POLLS;
    cfg_data_i <= {8'h00, drv};
    @(posedge clk_i);
    cfg_idx_i  <= REG_PRESSURE_POLLS;
    cfg_data_i <= {8'h00, prs};
    @(posedge clk_i);
    cfg_idx_i  <= REG_STOP_POLLS;
    cfg_data_i <= {8'h00, stp};
    @(posedge clk_i);
    cfg_idx_i  <= REG_MUTE_MS;
    cfg_data_i <= mute;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_q     = limit;
    drv_polls_q = drv;
    prs_polls_q = prs;
    stp_polls_q = stp;
    mute_q      = mute;
  endtask

  // Most of the traffic is runs of polls with steady line levels, so the
  // debounce counters actually reach their limits; the rest is noise.
  task automatic run_random(int unsigned n);
    int unsigned sent;
    int unsigned burst;
    bit          alarm;
    bit          over;
    bit          open;
    in_item_t    it;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 15))
        0: begin
          send_item(noise_item(OP_CLEAR));
          sent++;
        end
        1: begin
          it = noise_item(OP_SET);
          if ($urandom_range(0, 1) == 1) it.set_bits = 8'h01 << $urandom_range(0, 3);
          send_item(it);
          sent++;
        end
        2: begin
          send_item(noise_item(OpUnused));
          sent++;
        end
        default: begin
          burst = $urandom_range(1, 8);
          alarm = 1'($urandom());
          over  = 1'($urandom());
          open  = 1'($urandom());
          repeat (burst) begin
            send_item(poll_item(alarm, over, open));
            sent++;
          end
        end
      endcase
    end
  endtask

  task automatic test_directed();
    send_item(mk(OpUnused, 1, -1, 1, 32'hFFFF_FFFF, 8'hFF));
    send_item(mk(OP_POLL, 0, -32768, 0, 0, 0));
    send_item(mk(OP_POLL, 0, 400, 0, 10, 0));
    for (int i = 0; i < 5; i++) send_item(mk(OP_POLL, 1, 32767, 0, 20 + i, 0));
    send_item(mk(OP_SET, 0, 0, 0, 0, 8'h08));
    send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0));
    send_item(mk(OP_POLL, 0, 0, 0, 30, 0));
    send_item(mk(OP_SET, 0, 0, 0, 0, 8'h08));
    send_item(mk(OP_POLL, 0, 0, 0, 32'hFFFF_FFF0, 0));
    send_item(mk(OP_POLL, 0, 0, 0, 32'h0000_0F00, 0));
    send_item(mk(OP_POLL, 0, 0, 0, 32'h0000_0FA0, 0));
    send_item(mk(OP_SET, 0, 0, 0, 0, 8'hF0));
    send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i < 3; i++) send_item(mk(OP_POLL, 0, 0, 1, 100000 + i, 0));
    send_item(mk(OP_POLL, 0, 0, 0, 200000, 0));
    send_item(mk(OP_SET, 0, 0, 0, 0, 8'hFF));
    send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0));
    send_item(mk(OP_POLL, 0, 0, 0, 200010, 0));
  endtask

  task automatic test_backpressure();
    src_gaps = 1'b0;
    hold_req = 1'b1;
    run_random(30);
    src_gaps = 1'b1;
  endtask

  task automatic test_random_mixed();
    configure(16'($urandom()), 8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
              8'($urandom_range(1, 6)), 16'($urandom_range(0, 3000)));
    run_random(30);
  endtask

  task automatic test_zero_polls();
    sink_stalls = 1'b0;
    configure(16'sd32767, 8'd0, 8'd0, 8'd0, 16'd0);
    run_random(50);
    sink_stalls = 1'b1;
  endtask

  task automatic test_saturation();
    src_gaps = 1'b0;
    configure(-16'sd32768, 8'd255, 8'd255, 8'd255, 16'hFFFF);
    repeat (260) send_item(poll_item(1'b1, 1'b1, 1'b1));
    run_random(20);
    src_gaps = 1'b1;
  endtask

  task automatic test_steady_stream();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    configure(PRESSURE_LIMIT_RST, DRIVER_POLLS_RST, PRESSURE_POLLS_RST, STOP_POLLS_RST,
              MUTE_MS_RST);
    run_random(60);
  endtask

  task automatic report_mismatch(string field, logic [7:0] want, logic [7:0] got);
    mismatches++;
    $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.item;
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none actual %p", $time, got);
      end else begin
        want = pending_status.pop_front();
        if (got.fault_code !== want.fault_code)
          report_mismatch("fault_code", want.fault_code, got.fault_code);
        if (got.faulted !== want.faulted)
          report_mismatch("faulted", 8'(want.faulted), 8'(got.faulted));
        if (got.motor_disable !== want.motor_disable)
          report_mismatch("motor_disable", 8'(want.motor_disable), 8'(got.motor_disable));
        if (got.red_led !== want.red_led)
          report_mismatch("red_led", 8'(want.red_led), 8'(got.red_led));
        if (got.tone !== want.tone)
          report_mismatch("tone", 8'(want.tone), 8'(got.tone));
        if (got.reboot_request !== want.reboot_request)
          report_mismatch("reboot_request", 8'(want.reboot_request),
                          8'(got.reboot_request));
      end
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.item  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_mixed();
    test_zero_polls();
    test_saturation();
    test_steady_stream();
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
